### design/flce_pkg.sv
package flce_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CAP_W   = 7;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int FIRST_W = 7;

    localparam logic [FIRST_W-1:0] NO_MATCH = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_GET    = 3'd1,
        CMD_SET    = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [WORD_W-1:0]  word;
        logic [CNT_W-1:0]   fill;
        logic               ok;
        logic [WORD_W-1:0]  word_out;
        logic [FIRST_W-1:0] first;
        logic [CNT_W-1:0]   count;
        logic               found;
    } pkt_t;

endpackage

### design/flce_cell.sv
module flce_cell
    import flce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [IDX_W-1:0] idx,
    input  logic             valid_in,
    input  pkt_t             pkt_in,
    output logic             valid_out,
    output pkt_t             pkt_out
);

    logic [WORD_W-1:0] word_reg;
    logic              valid_reg;
    pkt_t              pkt_reg;
    pkt_t              pkt_next;
    logic              wr;
    logic [CNT_W-1:0]  idx_ext;

    assign idx_ext = {1'b0, idx};

    always_comb
    begin
        pkt_next = pkt_in;
        wr       = 1'b0;
        case (pkt_in.cmd)
            CMD_APPEND:
            begin
                if (pkt_in.ok && idx_ext == pkt_in.fill)
                begin
                    wr = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (pkt_in.ok && idx_ext == CNT_W'(pkt_in.position))
                begin
                    pkt_next.word_out = word_reg;
                end
            end
            CMD_SET:
            begin
                if (pkt_in.ok && idx_ext == CNT_W'(pkt_in.position))
                begin
                    pkt_next.word_out = word_reg;
                    wr                = 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                if (idx_ext < pkt_in.fill && word_reg == pkt_in.word)
                begin
                    if (!pkt_in.found)
                    begin
                        pkt_next.first = FIRST_W'(idx);
                    end
                    pkt_next.found = 1'b1;
                    pkt_next.count = pkt_in.count + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_in && wr)
        begin
            word_reg <= pkt_in.word;
        end
        if (adv)
        begin
            pkt_reg <= pkt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    assign valid_out = valid_reg;
    assign pkt_out   = pkt_reg;

endmodule

### design/fixed_capacity_list_engine.sv
// list of up to 64 signed 32-bit words held one per cell in a chain of cells; every
// transaction walks the whole chain as a packet, one cell per cycle while the chain
// is not stalled, whatever the command, and its result is registered at the end of
// the chain; a new transaction is accepted once the previous packet has left the
// chain, including while its result still waits in the output register; a packet
// that reaches the end of the chain while that result is still waiting stalls the
// chain until it is taken
module fixed_capacity_list_engine
    import flce_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CAP_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [POS_W-1:0]          position,
    input  logic signed [WORD_W-1:0]  word_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      ok,
    output logic signed [WORD_W-1:0]  word_out,
    output logic signed [FIRST_W-1:0] first_match_res,
    output logic [CNT_W-1:0]          match_count,
    output logic                      found,
    output logic [CNT_W-1:0]          fill_level
);

    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic               busy_reg;
    logic               out_valid_reg;
    logic               ok_reg;
    logic [WORD_W-1:0]  word_out_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   fill_out_reg;

    logic [CAP_W-1:0]   cap_eff;
    logic               accept;
    logic               adv;
    logic               ok_in;
    logic               done;
    pkt_t               inject;

    logic               chain_vld [DEPTH+1];
    pkt_t               chain_pkt [DEPTH+1];

    assign cap_eff  = (cap_reg > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_reg;
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign done     = chain_vld[DEPTH];
    assign adv      = !(done && out_valid_reg && !out_ready);

    always_comb
    begin
        ok_in           = 1'b0;
        fill_count_next = fill_count_reg;
        case (cmd)
            CMD_APPEND:
            begin
                ok_in = CNT_W'(fill_count_reg) < CNT_W'(cap_eff);
                if (ok_in)
                begin
                    fill_count_next = fill_count_reg + CNT_W'(1);
                end
            end
            CMD_GET, CMD_SET:
            begin
                ok_in = CNT_W'(position) < fill_count_reg;
            end
            CMD_CLEAR:
            begin
                ok_in           = 1'b1;
                fill_count_next = '0;
            end
            CMD_SEARCH:
            begin
                ok_in = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        inject.cmd      = cmd;
        inject.position = position;
        inject.word     = word_in;
        inject.fill     = fill_count_reg;
        inject.ok       = ok_in;
        inject.word_out = '0;
        inject.first    = NO_MATCH;
        inject.count    = '0;
        inject.found    = 1'b0;
    end

    assign chain_vld[0] = accept;
    assign chain_pkt[0] = inject;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        flce_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .idx       (IDX_W'(i)),
            .valid_in  (chain_vld[i]),
            .pkt_in    (chain_pkt[i]),
            .valid_out (chain_vld[i+1]),
            .pkt_out   (chain_pkt[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_W'(DEPTH);
            fill_count_reg <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
                busy_reg       <= 1'b1;
            end
            else if (done && adv)
            begin
                busy_reg <= 1'b0;
            end
            if (done && adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && adv)
        begin
            ok_reg       <= chain_pkt[DEPTH].ok;
            word_out_reg <= chain_pkt[DEPTH].word_out;
            first_reg    <= chain_pkt[DEPTH].first;
            count_reg    <= chain_pkt[DEPTH].count;
            found_reg    <= chain_pkt[DEPTH].found;
            fill_out_reg <= fill_count_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign word_out        = word_out_reg;
    assign first_match_res = first_reg;
    assign match_count     = count_reg;
    assign found           = found_reg;
    assign fill_level      = fill_out_reg;

endmodule

### design/flce_checker.sv
module flce_checker
    import flce_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIRST_W-1:0] first_match_res,
    input logic [CNT_W-1:0]   match_count,
    input logic               found,
    input logic [CNT_W-1:0]   fill_level
);

    // one transaction in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a transaction while one is in flight");

    // a waiting result is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // search fields agree with each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> first_match_res == NO_MATCH && match_count == '0)
        else $error("no match but first index or count set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> first_match_res != NO_MATCH && match_count != '0
            && match_count <= fill_level)
        else $error("match reported with inconsistent index or count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_level <= CNT_W'(DEPTH))
        else $error("fill level beyond store depth");

endmodule

bind fixed_capacity_list_engine flce_checker u_flce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .first_match_res (first_match_res),
    .match_count     (match_count),
    .found           (found),
    .fill_level      (fill_level)
);
